@@ rtl/sdq_pkg.sv @@
package sdq_pkg;

    // Configuration port
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_ADDR_W-1:0] REG_MIN_MOVEMENT    = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_ALLOW_DIAGONALS = 1'b1;

    // Squared travel threshold, kept instead of the raw distance
    localparam int              MIN_MOVE_W = 12;
    localparam int              LIM_W      = 2 * MIN_MOVE_W;
    localparam logic [LIM_W-1:0] LIM_RESET = 24'd100;

    // Direction codes
    localparam int DIR_W     = 3;
    localparam int NUM_DIRS  = 8;
    localparam int NUM_AXIS  = 4;
    localparam int OUT_TDATA_W = 8;

    typedef logic [DIR_W-1:0] dir_t;

    localparam dir_t DIR_DOWN      = 3'd0;
    localparam dir_t DIR_UP        = 3'd1;
    localparam dir_t DIR_RIGHT     = 3'd2;
    localparam dir_t DIR_LEFT      = 3'd3;
    localparam dir_t DIR_DOWNRIGHT = 3'd4;
    localparam dir_t DIR_DOWNLEFT  = 3'd5;
    localparam dir_t DIR_UPLEFT    = 3'd6;
    localparam dir_t DIR_UPRIGHT   = 3'd7;

endpackage

@@ rtl/sdq_ref_stage.sv @@
module sdq_ref_stage
    import sdq_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_BITS-1:0] in_x,
    input  logic signed [COORD_BITS-1:0] in_y,
    input  logic [LIM_W-1:0]             lim2,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [COORD_BITS:0]   dx,
    output logic signed [COORD_BITS:0]   dy
);

    localparam int SQ_W   = 2 * COORD_BITS + 2;
    localparam int DIST_W = (SQ_W > LIM_W) ? SQ_W : LIM_W;

    logic                         a_valid_reg;
    logic signed [COORD_BITS-1:0] x_reg;
    logic signed [COORD_BITS-1:0] y_reg;
    logic signed [COORD_BITS-1:0] ref_x_reg;
    logic signed [COORD_BITS-1:0] ref_y_reg;
    logic                         b_valid_reg;
    logic signed [COORD_BITS:0]   dx_reg;
    logic signed [COORD_BITS:0]   dy_reg;

    logic                         b_free;
    logic                         a_go;
    logic signed [COORD_BITS:0]   dx_cur;
    logic signed [COORD_BITS:0]   dy_cur;
    logic signed [DIST_W-1:0]     dx_sq;
    logic signed [DIST_W-1:0]     dy_sq;
    logic [DIST_W-1:0]            dist2;
    logic                         long_move;

    // Handshake between input word, displacement register and next stage
    assign b_free   = !b_valid_reg || out_ready;
    assign a_go     = a_valid_reg && b_free;
    assign in_ready = !a_valid_reg || b_free;

    // Exact displacement from the reference point and its squared length
    assign dx_cur    = (COORD_BITS+1)'(x_reg) - (COORD_BITS+1)'(ref_x_reg);
    assign dy_cur    = (COORD_BITS+1)'(y_reg) - (COORD_BITS+1)'(ref_y_reg);
    assign dx_sq     = DIST_W'(dx_cur) * DIST_W'(dx_cur);
    assign dy_sq     = DIST_W'(dy_cur) * DIST_W'(dy_cur);
    assign dist2     = DIST_W'($unsigned(dx_sq + dy_sq));
    assign long_move = dist2 >= DIST_W'(lim2);

    // Control: input word and displacement valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            ref_x_reg   <= '0;
            ref_y_reg   <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (a_go)
            begin
                b_valid_reg <= long_move;
            end
            else if (out_ready)
            begin
                b_valid_reg <= 1'b0;
            end
            // Advance the reference point only on a long enough move
            if (a_go && long_move)
            begin
                ref_x_reg <= x_reg;
                ref_y_reg <= y_reg;
            end
        end
    end

    // Payload: hold sample and displacement
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            x_reg <= in_x;
            y_reg <= in_y;
        end
        if (a_go)
        begin
            dx_reg <= dx_cur;
            dy_reg <= dy_cur;
        end
    end

    assign out_valid = b_valid_reg;
    assign dx        = dx_reg;
    assign dy        = dy_reg;

endmodule

@@ rtl/sdq_dir_stage.sv @@
module sdq_dir_stage
    import sdq_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [COORD_BITS:0] dx,
    input  logic signed [COORD_BITS:0] dy,
    input  logic                       allow_diag,
    output logic                       out_valid,
    input  logic                       out_ready,
    output dir_t                       direction
);

    // Scores scaled by 1/5: axis 3*d, diagonal 2*(d1+d2); order and ties unchanged
    localparam int SCORE_W = COORD_BITS + 4;

    logic signed [SCORE_W-1:0] dxe;
    logic signed [SCORE_W-1:0] dye;
    logic signed [SCORE_W-1:0] ax_x;
    logic signed [SCORE_W-1:0] ax_y;
    logic signed [SCORE_W-1:0] dg_sum;
    logic signed [SCORE_W-1:0] dg_diff;
    logic signed [SCORE_W-1:0] score [NUM_DIRS];
    logic signed [SCORE_W-1:0] best;
    logic                      found;
    dir_t                      best_dir;

    logic                      go;
    logic                      emit;
    logic                      out_valid_reg;
    dir_t                      dir_reg;
    logic                      prev_valid_reg;
    dir_t                      prev_dir_reg;

    assign dxe     = SCORE_W'(dx);
    assign dye     = SCORE_W'(dy);
    assign ax_x    = (dxe <<< 1) + dxe;
    assign ax_y    = (dye <<< 1) + dye;
    assign dg_sum  = (dxe + dye) <<< 1;
    assign dg_diff = (dxe - dye) <<< 1;

    // Score every direction against the displacement
    always_comb
    begin
        score[DIR_DOWN]      = ax_y;
        score[DIR_UP]        = -ax_y;
        score[DIR_RIGHT]     = ax_x;
        score[DIR_LEFT]      = -ax_x;
        score[DIR_DOWNRIGHT] = dg_sum;
        score[DIR_DOWNLEFT]  = -dg_diff;
        score[DIR_UPLEFT]    = -dg_sum;
        score[DIR_UPRIGHT]   = dg_diff;
    end

    // Strict maximum over positive scores; first direction keeps a tie
    always_comb
    begin
        best     = '0;
        found    = 1'b0;
        best_dir = DIR_DOWN;
        for (int i = 0; i < NUM_DIRS; i++)
        begin
            if ((i < NUM_AXIS || allow_diag) && score[i] > best)
            begin
                best     = score[i];
                found    = 1'b1;
                best_dir = dir_t'(i);
            end
        end
    end

    assign in_ready = !out_valid_reg || out_ready;
    assign go       = in_valid && in_ready;
    assign emit     = found && (!prev_valid_reg || best_dir != prev_dir_reg);

    // Control: output word valid and last direction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            prev_valid_reg <= 1'b0;
            prev_dir_reg   <= DIR_DOWN;
        end
        else
        begin
            if (go && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (go && found)
            begin
                prev_valid_reg <= 1'b1;
                prev_dir_reg   <= best_dir;
            end
        end
    end

    // Payload: hold the emitted direction
    always_ff @(posedge clk)
    begin
        if (go && emit)
        begin
            dir_reg <= best_dir;
        end
    end

    assign out_valid = out_valid_reg;
    assign direction = dir_reg;

endmodule

@@ rtl/stroke_direction_quantizer_unit.sv @@
// A result word passes the sample register, then the displacement register, then the
// result register. Throughput: one sample per cycle while the output is not stalled by
// m_tready; the reference-point update (displacement, two squares and the threshold
// compare) is combinational between the sample and displacement registers.
// Reset (rst_n, async, active low): reference point (0,0), no previous
// direction, min_movement 10, allow_diagonals 1, all pipeline words empty.
module stroke_direction_quantizer_unit
    import sdq_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       s_tvalid,
    output logic                                       s_tready,
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]          s_tdata,  // pos_x, pos_y
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    output logic [OUT_TDATA_W-1:0]                     m_tdata,  // direction
    input  logic                                       cfg_we,
    input  logic [CFG_ADDR_W-1:0]                      cfg_addr,
    input  logic [CFG_DATA_W-1:0]                      cfg_data
);

    logic [LIM_W-1:0]             lim2_reg;
    logic                         allow_diag_reg;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic                         mid_valid;
    logic                         mid_ready;
    logic signed [COORD_BITS:0]   dx;
    logic signed [COORD_BITS:0]   dy;
    dir_t                         direction;

    // Configuration: keep the threshold squared
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim2_reg       <= LIM_RESET;
            allow_diag_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_MIN_MOVEMENT:
                begin
                    lim2_reg <= LIM_W'(cfg_data) * LIM_W'(cfg_data);
                end
                REG_ALLOW_DIAGONALS:
                begin
                    allow_diag_reg <= cfg_data[0];
                end
                default:
                begin
                    lim2_reg <= lim2_reg;
                end
            endcase
        end
    end

    assign pos_x = s_tdata[COORD_BITS-1:0];
    assign pos_y = s_tdata[2*COORD_BITS-1:COORD_BITS];

    sdq_ref_stage #(
        .COORD_BITS (COORD_BITS)
    ) u_ref (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_x      (pos_x),
        .in_y      (pos_y),
        .lim2      (lim2_reg),
        .out_valid (mid_valid),
        .out_ready (mid_ready),
        .dx        (dx),
        .dy        (dy)
    );

    sdq_dir_stage #(
        .COORD_BITS (COORD_BITS)
    ) u_dir (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (mid_valid),
        .in_ready   (mid_ready),
        .dx         (dx),
        .dy         (dy),
        .allow_diag (allow_diag_reg),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .direction  (direction)
    );

    assign m_tdata = OUT_TDATA_W'(direction);

endmodule
